### hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder package
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Frame layout and byte counter codes.
   localparam int unsigned STORED_BYTES = 4;
   localparam logic [2:0] COUNT_IDLE = 3'd0;
   localparam logic [2:0] COUNT_LAST = 3'd4;
   localparam logic [2:0] COUNT_DONE = 3'd5;

   // CRC-8, polynomial 0x31, initial value zero, MSB first.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // Reset value of the header nibble register.
   localparam logic [3:0] HEADER_RESET = 4'h9;

   // Temperature decode constants.
   localparam logic [11:0] TEMP_WEIGHT_HUNDREDS = 12'd100;
   localparam logic [11:0] TEMP_WEIGHT_TENS = 12'd10;
   localparam logic [11:0] TEMP_OFFSET = 12'd400;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_HEADER = 2'd1,
      STATUS_CRC    = 2'd2
   } status_type;

   typedef logic [7:0] byte_type;

   // One completed frame as captured by the tracker.
   typedef struct packed {
      status_type              status;
      byte_type [STORED_BYTES-1:0] bytes;
   } frame_type;

   // One decoded result word.
   typedef struct packed {
      status_type         status;
      logic [5:0]         sensor_id;
      logic               weak_battery;
      logic signed [11:0] temperature_tenths;
      logic [6:0]         humidity;
   } result_type;

   // Handshake between the frame tracker and the result stage.
   typedef struct packed {
      logic valid;
      logic take;
   } stage_ctrl_type;

   // One byte of CRC-8 update, eight shift steps unrolled.
   function automatic byte_type crc_byte(byte_type crc, byte_type data);
      byte_type v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

### hw/rtl/sfd_if.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder channel interfaces
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface sfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded result channel.
interface sfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [5:0]         sensor_id;
   logic               weak_battery;
   logic signed [11:0] temperature_tenths;
   logic [6:0]         humidity;

   modport source (output valid, output status, output sensor_id, output weak_battery,
                   output temperature_tenths, output humidity, input ready);
   modport sink (input valid, input status, input sensor_id, input weak_battery,
                 input temperature_tenths, input humidity, output ready);
endinterface

### hw/rtl/sfd_frame_track.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder frame tracker
// The frame tracker is the module sfd_frame_tracker in sfd_frame_tracker.sv.
// ----------------------------------------------------------------------------

### hw/rtl/sfd_frame_tracker.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder frame tracker
// Counts bytes, stores the first four, runs the CRC and captures each frame.
// ----------------------------------------------------------------------------
module sfd_frame_tracker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              rx_byte,
   input  logic                    frame_start,
   input  logic [3:0]              header_nibble,
   input  sfd_pkg::stage_ctrl_type stage_in,
   output logic                    frame_valid,
   output sfd_pkg::frame_type      frame_word
);

   logic [2:0]                   count_ff, count_in;
   sfd_pkg::byte_type            crc_ff, crc_in;
   sfd_pkg::byte_type [sfd_pkg::STORED_BYTES-1:0] bytes_ff;
   logic                         valid_ff, valid_in;
   sfd_pkg::frame_type           frame_ff;

   logic                         accept;
   logic                         active;
   logic [2:0]                   position;
   sfd_pkg::byte_type            crc_next;
   logic                         is_last;
   logic                         store;
   sfd_pkg::status_type          status;

   // A byte is taken unless a captured frame is still waiting downstream.
   assign in_ready = !valid_ff || stage_in.take;
   assign accept = in_valid && in_ready;

   // A frame start restarts the count; other bytes count only inside a frame.
   assign position = frame_start ? sfd_pkg::COUNT_IDLE : count_ff;
   assign active = frame_start ||
                   ((count_ff != sfd_pkg::COUNT_IDLE) && (count_ff < sfd_pkg::COUNT_DONE));
   assign crc_next = sfd_pkg::crc_byte(frame_start ? sfd_pkg::CRC_INIT : crc_ff, rx_byte);
   assign is_last = accept && active && (position == sfd_pkg::COUNT_LAST);
   assign store = accept && active && (position < sfd_pkg::COUNT_LAST);

   // The header check has priority over the CRC check.
   always_comb begin
      if (bytes_ff[0][7:4] != header_nibble) begin
         status = sfd_pkg::STATUS_HEADER;
      end else if (crc_next != sfd_pkg::CRC_INIT) begin
         status = sfd_pkg::STATUS_CRC;
      end else begin
         status = sfd_pkg::STATUS_OK;
      end
   end

   // Next count and running CRC.
   always_comb begin
      count_in = count_ff;
      crc_in = crc_ff;
      if (accept && active) begin
         crc_in = crc_next;
         if (position == sfd_pkg::COUNT_LAST) begin
            count_in = sfd_pkg::COUNT_DONE;
         end else begin
            count_in = position + 3'd1;
         end
      end
   end

   // The capture register holds a frame until the result stage takes it.
   always_comb begin
      valid_in = valid_ff;
      if (stage_in.take) begin
         valid_in = 1'b0;
      end
      if (is_last) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= sfd_pkg::COUNT_IDLE;
         crc_ff <= sfd_pkg::CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff <= crc_in;
         valid_ff <= valid_in;
      end
   end

   // Stored frame bytes and the captured frame word.
   always_ff @(posedge clock) begin
      if (store) begin
         bytes_ff[position[1:0]] <= rx_byte;
      end
      if (is_last) begin
         frame_ff.status <= status;
         frame_ff.bytes <= bytes_ff;
      end
   end

   assign frame_valid = valid_ff;
   assign frame_word = frame_ff;

endmodule

### hw/rtl/sfd_result_stage.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder result stage
// Decodes a captured frame into result fields and holds the result word.
// ----------------------------------------------------------------------------
module sfd_result_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    frame_valid,
   input  sfd_pkg::frame_type      frame_word,
   output sfd_pkg::stage_ctrl_type stage_out,
   output logic                    out_valid,
   input  logic                    out_ready,
   output sfd_pkg::result_type     out_word
);

   logic                valid_ff, valid_in;
   sfd_pkg::result_type result_ff, result_in;
   logic                load;
   logic [11:0]         temp_sum;

   // Load when a frame waits and the output register is free or being drained.
   assign load = frame_valid && (!valid_ff || out_ready);
   assign stage_out.valid = frame_valid;
   assign stage_out.take = load;

   // Weighted BCD digits minus the offset; digits above nine are not checked.
   assign temp_sum = 12'(frame_word.bytes[1][3:0]) * sfd_pkg::TEMP_WEIGHT_HUNDREDS
                   + 12'(frame_word.bytes[2][7:4]) * sfd_pkg::TEMP_WEIGHT_TENS
                   + 12'(frame_word.bytes[2][3:0])
                   - sfd_pkg::TEMP_OFFSET;

   // Failed frames report only the status; all measurement fields are zero.
   always_comb begin
      result_in = '0;
      result_in.status = frame_word.status;
      if (frame_word.status == sfd_pkg::STATUS_OK) begin
         result_in.sensor_id = {frame_word.bytes[0][3:0], frame_word.bytes[1][7:6]};
         result_in.weak_battery = frame_word.bytes[3][7];
         result_in.temperature_tenths = $signed(temp_sum);
         result_in.humidity = frame_word.bytes[3][6:0];
      end
   end

   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word = result_ff;

endmodule

### hw/rtl/sensor_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// Sensor frame decoder core
// Decodes five-byte weather-sensor frames into status and measurement words.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle on the request channel; a byte
// flagged as frame start begins a new frame and discards any partial one. The
// fifth byte of a frame produces one result word, which passes first through
// the frame capture register, where the CRC-8 (polynomial 0x31) and header
// checks are made, and then through the output register, where the fields are
// decoded. Bytes outside a frame are dropped without a result. The request
// channel stalls only when a captured frame and a held result both wait on the
// response channel. The header nibble register resets to 9; the user must write
// it through the csr port only while idle, as the block does not enforce this.
module sensor_frame_decoder_core (
   input  logic       clock,
   input  logic       reset,
   sfd_req_if.sink    req_chan,
   sfd_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic [3:0]              header_ff;
   logic                    frame_valid;
   sfd_pkg::frame_type      frame_word;
   sfd_pkg::stage_ctrl_type stage_ctrl;
   sfd_pkg::result_type     result;

   // Expected header nibble register.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= sfd_pkg::HEADER_RESET;
      end else if (csr_wr_en) begin
         header_ff <= csr_wr_data;
      end
   end

   // Byte counting, CRC and frame capture.
   sfd_frame_tracker u_tracker (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_chan.valid),
      .in_ready      (req_chan.ready),
      .rx_byte       (req_chan.rx_byte),
      .frame_start   (req_chan.frame_start),
      .header_nibble (header_ff),
      .stage_in      (stage_ctrl),
      .frame_valid   (frame_valid),
      .frame_word    (frame_word)
   );

   // Field decode and output register.
   sfd_result_stage u_result (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_word  (frame_word),
      .stage_out   (stage_ctrl),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_word    (result)
   );

   assign rsp_chan.status = result.status;
   assign rsp_chan.sensor_id = result.sensor_id;
   assign rsp_chan.weak_battery = result.weak_battery;
   assign rsp_chan.temperature_tenths = result.temperature_tenths;
   assign rsp_chan.humidity = result.humidity;

endmodule

### bench/tb_sensor_frame_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame decoder core testbench
// Streams received radio bytes into the decoder and predicts every decoded
// frame. A short directed part covers the field extremes, the status codes
// and the stream special cases. Random phases follow with varied header
// settings and varied idling on both channels. Every result word is compared
// field by field against the predicted frame.
// ----------------------------------------------------------------------------
module tb_sensor_frame_decoder_core;

   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_BYTES = 50;

   // Tracks the byte stream as the decoder sees it and keeps the decoded
   // frames that are still due on the result channel.
   class frame_tracker;
      logic [3:0] header_nibble;
      logic [2:0] bytes_seen;
      logic [7:0] crc_acc;
      logic [7:0] held [4];
      sfd_pkg::result_type decoded_frames [$];
      int errors;
      int used_bytes;

      function new();
         header_nibble = sfd_pkg::HEADER_RESET;
         bytes_seen = sfd_pkg::COUNT_IDLE;
         crc_acc = sfd_pkg::CRC_INIT;
         errors = 0;
         used_bytes = 0;
      endfunction

      // Bitwise CRC-8 update, feeding the data bits MSB first.
      static function logic [7:0] crc8_step(logic [7:0] acc, logic [7:0] data);
         logic feedback;
         for (int i = 7; i >= 0; i--) begin
            feedback = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (feedback ? sfd_pkg::CRC_POLY : 8'h00);
         end
         return acc;
      endfunction

      function void set_header(logic [3:0] value);
         header_nibble = value;
      endfunction

      function int pending();
         return decoded_frames.size();
      endfunction

      // Follows one accepted byte; a fifth frame byte queues a decoded frame.
      function void absorb_byte(logic [7:0] data, logic start);
         logic [7:0] crc_next;
         sfd_pkg::result_type frame;
         int tenths;
         if (start) begin
            bytes_seen = sfd_pkg::COUNT_IDLE;
            crc_acc = sfd_pkg::CRC_INIT;
         end else if (bytes_seen == sfd_pkg::COUNT_IDLE ||
                      bytes_seen >= sfd_pkg::COUNT_DONE) begin
            return;
         end
         used_bytes++;
         crc_next = crc8_step(crc_acc, data);
         crc_acc = crc_next;
         if (bytes_seen < sfd_pkg::COUNT_LAST) begin
            held[bytes_seen[1:0]] = data;
            bytes_seen++;
            return;
         end
         bytes_seen = sfd_pkg::COUNT_DONE;
         frame = '0;
         // The header check wins over the CRC check.
         if (held[0][7:4] != header_nibble) begin
            frame.status = sfd_pkg::STATUS_HEADER;
         end else if (crc_next != 8'h00) begin
            frame.status = sfd_pkg::STATUS_CRC;
         end else begin
            frame.status = sfd_pkg::STATUS_OK;
            frame.sensor_id = {held[0][3:0], held[1][7:6]};
            frame.weak_battery = held[3][7];
            tenths = 100 * int'(held[1][3:0]) + 10 * int'(held[2][7:4])
                     + int'(held[2][3:0]) - 400;
            frame.temperature_tenths = tenths[11:0];
            frame.humidity = held[3][6:0];
         end
         decoded_frames.push_back(frame);
      endfunction

      // Compares one received word with the oldest decoded frame.
      function void compare_word(sfd_pkg::result_type got);
         sfd_pkg::result_type want;
         if (decoded_frames.size() == 0) begin
            $error("unexpected result word: status %0d sensor_id %0d",
                   got.status, got.sensor_id);
            errors++;
            return;
         end
         want = decoded_frames.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.sensor_id !== want.sensor_id) begin
            $error("sensor_id: expected %0d, actual %0d", want.sensor_id, got.sensor_id);
            errors++;
         end
         if (got.weak_battery !== want.weak_battery) begin
            $error("weak_battery: expected %0d, actual %0d",
                   want.weak_battery, got.weak_battery);
            errors++;
         end
         if (got.temperature_tenths !== want.temperature_tenths) begin
            $error("temperature_tenths: expected %0d, actual %0d",
                   want.temperature_tenths, got.temperature_tenths);
            errors++;
         end
         if (got.humidity !== want.humidity) begin
            $error("humidity: expected %0d, actual %0d", want.humidity, got.humidity);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [3:0] csr_wr_data;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   frame_tracker tracker = new();

   sfd_req_if req_bus();
   sfd_rsp_if rsp_bus();

   sensor_frame_decoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random stalls, and a check of every accepted word.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            tracker.compare_word(sfd_pkg::result_type'({rsp_bus.status, rsp_bus.sensor_id,
                                                        rsp_bus.weak_battery,
                                                        rsp_bus.temperature_tenths,
                                                        rsp_bus.humidity}));
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Ends the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one byte, with random idle cycles first, and returns once it is
   // accepted. Valid stays high so back-to-back bytes need no extra step.
   task automatic send_byte(input logic [7:0] data, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= data;
      req_bus.frame_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      tracker.absorb_byte(data, start);
   endtask

   // Sends the first count bytes of a frame, byte 0 in the top bits.
   task automatic send_frame(input logic [39:0] frame, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(frame[39 - 8 * i -: 8], i == 0);
      end
   endtask

   // Builds a frame whose last byte makes the CRC over all five come out zero.
   function automatic logic [39:0] seal(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3);
      logic [7:0] acc;
      acc = frame_tracker::crc8_step(sfd_pkg::CRC_INIT, b0);
      acc = frame_tracker::crc8_step(acc, b1);
      acc = frame_tracker::crc8_step(acc, b2);
      acc = frame_tracker::crc8_step(acc, b3);
      return {b0, b1, b2, b3, acc};
   endfunction

   // Holds the sender off until every decoded frame has come out.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_header(input logic [3:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_header(value);
   endtask

   // One random stretch of stream: mostly whole frames, some noise.
   task automatic send_random_stretch();
      int kind;
      int count;
      logic [3:0] hdr;
      logic [39:0] frame;
      kind = $urandom_range(99);
      hdr = ($urandom_range(99) < 88) ? tracker.header_nibble : 4'($urandom_range(15));
      frame = seal({hdr, 4'($urandom_range(15))}, 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      if (kind < 72) begin
         if ($urandom_range(99) < 15) begin
            frame[7:0] = 8'($urandom_range(255));
         end
         send_frame(frame, 5);
      end else if (kind < 84) begin
         send_frame(frame, $urandom_range(1, 4));
      end else begin
         // Loose bytes; below 92 the start flag is random, from 92 up it is clear.
         count = $urandom_range(1, 3);
         for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom_range(255)), (kind < 92) ? 1'($urandom_range(1)) : 1'b0);
         end
      end
   endtask

   initial begin
      int goal;
      bit paused;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 4'h0;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'h00;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset header value.
      send_byte(8'h3C, 1'b0);
      send_frame(seal(8'h9F, 8'hFF, 8'hFF, 8'hFF), 5);
      send_byte(8'h00, 1'b0);
      send_frame(seal(8'h91, 8'h22, 8'h33, 8'h44), 2);
      send_frame(seal(8'h90, 8'h00, 8'h00, 8'h6A), 5);
      send_frame(seal(8'h5A, 8'h12, 8'h34, 8'h56) ^ 40'h1, 5);
      send_frame(seal(8'h9A, 8'h87, 8'h65, 8'hC3) ^ 40'h80, 5);
      wait_drained();

      // Random phases, each with its own header value and idling mode.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         write_header((phase == 0) ? 4'h0 : (phase == 1) ? 4'hF : 4'($urandom_range(15)));
         goal = tracker.used_bytes + PHASE_BYTES;
         paused = 1'b0;
         while (tracker.used_bytes < goal) begin
            send_random_stretch();
            if (!paused && tracker.used_bytes >= goal - PHASE_BYTES / 2) begin
               paused = 1'b1;
               wait_drained();
            end
         end
         wait_drained();
      end

      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d decoded frames never came out", tracker.pending());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
